### design/srwr_pkg.sv
package srwr_pkg;

    // Command codes carried with each input beat.
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ROOT  = 2'd1;
    localparam logic [1:0] CMD_SENT  = 2'd2;

    // Word separator in the sentence stream.
    localparam logic [7:0] SPACE_CHAR = 8'd32;

    // One input beat as it travels through the block.
    typedef struct packed {
        logic [1:0] command;
        logic [7:0] ch;
        logic       last;
    } item_t;

endpackage

### design/srwr_root_store.sv
module srwr_root_store #(
    parameter int MAX_ROOTS    = 64,
    parameter int MAX_ROOT_LEN = 32,
    localparam int RIW = (MAX_ROOTS > 1) ? $clog2(MAX_ROOTS) : 1,
    localparam int RCW = $clog2(MAX_ROOTS + 1),
    localparam int LIW = (MAX_ROOT_LEN > 1) ? $clog2(MAX_ROOT_LEN) : 1,
    localparam int PW  = $clog2(MAX_ROOT_LEN + 1)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  srwr_pkg::item_t item_in,
    input  logic            item_accept,
    input  srwr_pkg::item_t s1_item,
    input  logic            s1_fire,
    input  logic [PW-1:0]   word_pos_next,
    output logic [MAX_ROOTS*8-1:0] row,
    output logic [RCW-1:0]  root_count,
    output logic [PW-1:0]   root_len [MAX_ROOTS],
    output logic            root_add
);
    import srwr_pkg::*;

    localparam logic [PW-1:0]  ROOT_LEN_P = PW'(MAX_ROOT_LEN);
    localparam logic [RCW-1:0] ROOT_CNT   = RCW'(MAX_ROOTS);

    // Root letters: one row per letter position, one byte lane per root.
    logic [MAX_ROOTS*8-1:0] mem [MAX_ROOT_LEN];
    logic [MAX_ROOTS*8-1:0] row_reg;
    logic [PW-1:0]          len_reg [MAX_ROOTS];

    logic [PW-1:0]  lp_reg, lp_next, lp_inc;
    logic [RCW-1:0] rc_reg, rc_next;
    logic           tl_reg, tl_next, tl_inc;
    logic           lp_step;
    logic           commit;
    logic           wr_en;
    logic           rd_en;

    // Load position, overflow flag and root count follow each root beat and are emptied by a clear beat.
    always_comb
    begin
        lp_step = (lp_reg < ROOT_LEN_P);
        lp_inc  = lp_step ? lp_reg + 1'b1 : lp_reg;
        tl_inc  = tl_reg | ~lp_step;
        commit  = s1_fire && (s1_item.command == CMD_ROOT) && s1_item.last && !tl_inc
                  && (rc_reg < ROOT_CNT) && (lp_inc != '0);
        lp_next = lp_reg;
        tl_next = tl_reg;
        rc_next = rc_reg;
        if (s1_fire)
        begin
            unique case (s1_item.command)
                CMD_CLEAR:
                begin
                    lp_next = '0;
                    tl_next = 1'b0;
                    rc_next = '0;
                end
                CMD_ROOT:
                begin
                    if (s1_item.last)
                    begin
                        lp_next = '0;
                        tl_next = 1'b0;
                        if (commit)
                        begin
                            rc_next = rc_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        lp_next = lp_inc;
                        tl_next = tl_inc;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lp_reg <= '0;
            tl_reg <= 1'b0;
            rc_reg <= '0;
        end
        else
        begin
            lp_reg <= lp_next;
            tl_reg <= tl_next;
            rc_reg <= rc_next;
        end
    end

    // Lengths are only read below the root count, so they need no reset.
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            len_reg[rc_reg[RIW-1:0]] <= lp_inc;
        end
    end

    // A root letter is written when its beat is taken, using the load state
    // that the item ahead of it leaves, so a following sentence beat sees it.
    assign wr_en = item_accept && (item_in.command == CMD_ROOT)
                   && (lp_next < ROOT_LEN_P) && (rc_next < ROOT_CNT);
    assign rd_en = item_accept && (item_in.command == CMD_SENT)
                   && (word_pos_next < ROOT_LEN_P);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[lp_next[LIW-1:0]][{rc_next[RIW-1:0], 3'b000} +: 8] <= item_in.ch;
        end
        if (rd_en)
        begin
            row_reg <= mem[word_pos_next[LIW-1:0]];
        end
    end

    assign row        = row_reg;
    assign root_count = rc_reg;
    assign root_len   = len_reg;
    assign root_add   = commit;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rc_reg <= ROOT_CNT)
        else $error("root count beyond table capacity");

    a_overflow_pos: assert property (@(posedge clk) disable iff (!rst_n)
        tl_reg |-> (lp_reg == ROOT_LEN_P))
        else $error("overlong root flagged before position saturated");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && (s1_item.command == CMD_CLEAR)) |=> (rc_reg == '0 && lp_reg == '0))
        else $error("clear did not empty the dictionary");

endmodule

### design/srwr_matcher.sv
module srwr_matcher #(
    parameter int MAX_ROOTS    = 64,
    parameter int MAX_ROOT_LEN = 32,
    localparam int RIW = (MAX_ROOTS > 1) ? $clog2(MAX_ROOTS) : 1,
    localparam int RCW = $clog2(MAX_ROOTS + 1),
    localparam int PW  = $clog2(MAX_ROOT_LEN + 1)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  srwr_pkg::item_t s1_item,
    input  logic            s1_fire,
    input  logic [MAX_ROOTS*8-1:0] row,
    input  logic [RCW-1:0]  root_count,
    input  logic [PW-1:0]   root_len [MAX_ROOTS],
    input  logic            root_add,
    output logic [PW-1:0]   word_pos_next,
    output logic            keep
);
    import srwr_pkg::*;

    localparam logic [PW-1:0] ROOT_LEN_P = PW'(MAX_ROOT_LEN);

    logic [MAX_ROOTS-1:0] alive_reg, alive_next;
    logic [MAX_ROOTS-1:0] active;
    logic [MAX_ROOTS-1:0] mismatch;
    logic [MAX_ROOTS-1:0] lane_hit;
    logic [PW-1:0]        wp_reg, wp_next;
    logic                 skip_reg, skip_next;
    logic                 pos_ok;
    logic                 is_space;
    logic                 hit;

    // Every root lane compares its letter at the current word position.
    always_comb
    begin
        pos_ok = (wp_reg < ROOT_LEN_P);
        for (int i = 0; i < MAX_ROOTS; i++)
        begin
            active[i]   = (RCW'(i) < root_count);
            mismatch[i] = !pos_ok || (wp_reg >= root_len[i])
                          || (row[i*8 +: 8] != s1_item.ch);
            lane_hit[i] = active[i] && alive_reg[i] && !mismatch[i]
                          && (root_len[i] == wp_reg + 1'b1);
        end
        hit = |lane_hit;
    end

    // Word state update for the beat leaving the input stage.
    always_comb
    begin
        is_space   = (s1_item.ch == SPACE_CHAR);
        alive_next = alive_reg;
        wp_next    = wp_reg;
        skip_next  = skip_reg;
        if (s1_fire)
        begin
            unique case (s1_item.command)
                CMD_CLEAR:
                begin
                    alive_next = '1;
                    wp_next    = '0;
                    skip_next  = 1'b0;
                end
                CMD_ROOT:
                begin
                    if (root_add)
                    begin
                        alive_next[root_count[RIW-1:0]] = (wp_reg == '0) && !skip_reg;
                    end
                end
                CMD_SENT:
                begin
                    if (is_space || s1_item.last)
                    begin
                        alive_next = '1;
                        wp_next    = '0;
                        skip_next  = 1'b0;
                    end
                    else if (!skip_reg)
                    begin
                        alive_next = alive_reg & ~(active & mismatch);
                        wp_next    = pos_ok ? wp_reg + 1'b1 : wp_reg;
                        skip_next  = hit;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alive_reg <= '1;
            wp_reg    <= '0;
            skip_reg  <= 1'b0;
        end
        else
        begin
            alive_reg <= alive_next;
            wp_reg    <= wp_next;
            skip_reg  <= skip_next;
        end
    end

    assign word_pos_next = wp_next;
    assign keep          = is_space || !skip_reg;

    a_skip_after_letter: assert property (@(posedge clk) disable iff (!rst_n)
        skip_reg |-> (wp_reg != '0))
        else $error("suppression active with no letter matched");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg <= ROOT_LEN_P)
        else $error("word position past saturation");

    a_sentence_end: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && (s1_item.command == CMD_SENT) && s1_item.last)
        |=> (wp_reg == '0 && !skip_reg && alive_reg == '1))
        else $error("word state not restarted after sentence end");

endmodule

### design/shortest_root_word_replacer_core.sv
// Shortest-root word replacer. Load roots with root beats (one letter per
// beat, last_char on the final letter) after a clear beat, then stream the
// sentence with sentence beats; every sentence beat returns one result beat
// with the same character, char_valid low where the letter is dropped after
// the shortest matching root, and end_of_sentence on the final character.
// Clear and root beats return nothing. The block takes one beat per cycle
// while the input stage can pass its beat on, and the input stage
// reads one row of the root letter memory (the row for the current letter
// position, holding that letter of every root) and the compare of all roots
// runs between that stage and the result register. A sentence beat waits
// in the input stage only while the result register is full and not taken.
// No clearing pass follows reset; the root count bounds what is matched.
module shortest_root_word_replacer_core #(
    parameter int MAX_ROOTS    = 64,
    parameter int MAX_ROOT_LEN = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [1:0] command,
    input  logic [7:0] in_char,
    input  logic       last_char,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [7:0] out_char,
    output logic       char_valid,
    output logic       end_of_sentence
);
    import srwr_pkg::*;

    localparam int RCW = $clog2(MAX_ROOTS + 1);
    localparam int PW  = $clog2(MAX_ROOT_LEN + 1);

    item_t                  item_in;
    item_t                  s1_item_reg;
    logic                   s1_valid_reg, s1_valid_next;
    logic                   s1_fire;
    logic                   accept;
    logic                   emit;
    logic [MAX_ROOTS*8-1:0] row;
    logic [RCW-1:0]         root_count;
    logic [PW-1:0]          root_len [MAX_ROOTS];
    logic                   root_add;
    logic [PW-1:0]          word_pos_next;
    logic                   keep;
    logic                   res_valid_reg, res_valid_next;
    logic [7:0]             res_char_reg;
    logic                   res_keep_reg;
    logic                   res_eos_reg;

    assign item_in = '{command: command, ch: in_char, last: last_char};

    // Input stage: a beat leaves unless it needs the result register and
    // that register is still holding a beat nobody has taken.
    assign s1_fire = s1_valid_reg && ((s1_item_reg.command != CMD_SENT)
                     || !res_valid_reg || result_ready);
    assign item_ready = !s1_valid_reg || s1_fire;
    assign accept     = item_valid && item_ready;
    assign emit       = s1_fire && (s1_item_reg.command == CMD_SENT);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (emit)
        begin
            res_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers of both stages.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= item_in;
        end
        if (emit)
        begin
            res_char_reg <= s1_item_reg.ch;
            res_keep_reg <= keep;
            res_eos_reg  <= s1_item_reg.last;
        end
    end

    srwr_root_store #(
        .MAX_ROOTS    (MAX_ROOTS),
        .MAX_ROOT_LEN (MAX_ROOT_LEN)
    ) u_store (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_in       (item_in),
        .item_accept   (accept),
        .s1_item       (s1_item_reg),
        .s1_fire       (s1_fire),
        .word_pos_next (word_pos_next),
        .row           (row),
        .root_count    (root_count),
        .root_len      (root_len),
        .root_add      (root_add)
    );

    srwr_matcher #(
        .MAX_ROOTS    (MAX_ROOTS),
        .MAX_ROOT_LEN (MAX_ROOT_LEN)
    ) u_matcher (
        .clk           (clk),
        .rst_n         (rst_n),
        .s1_item       (s1_item_reg),
        .s1_fire       (s1_fire),
        .row           (row),
        .root_count    (root_count),
        .root_len      (root_len),
        .root_add      (root_add),
        .word_pos_next (word_pos_next),
        .keep          (keep)
    );

    assign result_valid    = res_valid_reg;
    assign out_char        = res_char_reg;
    assign char_valid      = res_keep_reg;
    assign end_of_sentence = res_eos_reg;

endmodule
